// File: rtl/mmdf_pkg.sv
// Package for the moving mean difference filter.
// Holds the sample width, the sequencer state type and the control structs.
// No dependencies.
`default_nettype none

package mmdf_pkg;

  localparam int SAMPLE_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
  } win_ctrl_t;

  typedef struct packed {
    logic load;
    logic busy;
  } div_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mmdf_in_if.sv
// Input channel of the moving mean difference filter: one sample per beat.
// Depends on mmdf_pkg.
`default_nettype none

interface mmdf_in_if import mmdf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       starts_block;

  modport source (output valid, output sample_value, output starts_block, input ready);
  modport sink (input valid, input sample_value, input starts_block, output ready);
endinterface

`default_nettype wire

// File: rtl/mmdf_out_if.sv
// Result channel of the moving mean difference filter: one result per beat.
// Depends on mmdf_pkg.
`default_nettype none

interface mmdf_out_if import mmdf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean_minus_sample;
  logic signed [SAMPLE_W-1:0] window_mean;

  modport source (output valid, output mean_minus_sample, output window_mean, input ready);
  modport sink (input valid, input mean_minus_sample, input window_mean, output ready);
endinterface

`default_nettype wire

// File: rtl/mmdf_window.sv
// Sample window memory with running sum, write index and fill count.
// Depends on mmdf_pkg.
`default_nettype none

module mmdf_window import mmdf_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  win_ctrl_t                              ctrl,
  input  wire  signed [SAMPLE_W-1:0]             sample_value,
  input  wire                                    starts_block,
  output logic signed [SAMPLE_W+$clog2(WINDOW)-1:0] sum_nxt,
  output logic        [$clog2(WINDOW+1)-1:0]     count_nxt,
  output logic signed [SAMPLE_W-1:0]             cur_sample
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];

  logic signed [SUM_W-1:0]    sum_r;
  logic        [IDX_W-1:0]    idx_r;
  logic        [CNT_W-1:0]    count_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic                       old_valid_r;

  logic [IDX_W-1:0] wr_idx;
  logic             full;
  logic signed [SUM_W-1:0] old_term;

  // Writes run in order from index zero after a clear, so the entry under the
  // write index holds a live sample only once the window is full.
  assign full   = (count_r == CNT_W'(WINDOW));
  assign wr_idx = starts_block ? '0 : idx_r;

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      old_r       <= mem[wr_idx];
      mem[wr_idx] <= sample_value;
      sample_r    <= sample_value;
      old_valid_r <= full && !starts_block;
    end
  end

  assign old_term   = old_valid_r ? SUM_W'(old_r) : '0;
  assign sum_nxt    = sum_r - old_term + SUM_W'(sample_r);
  assign count_nxt  = full ? count_r : count_r + CNT_W'(1);
  assign cur_sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      idx_r   <= '0;
      count_r <= '0;
    end else if (ctrl.accept && starts_block) begin
      sum_r   <= '0;
      idx_r   <= '0;
      count_r <= '0;
    end else if (ctrl.update) begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      if (idx_r == IDX_W'(WINDOW - 1)) begin
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mmdf_divider.sv
// Bit-serial restoring divider: signed sum over unsigned fill count,
// one quotient bit per cycle, truncating toward zero. Depends on mmdf_pkg.
`default_nettype none

module mmdf_divider import mmdf_pkg::*; #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 5
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         load,
  input  wire  signed [DIVIDEND_W-1:0] dividend,
  input  wire         [DIVISOR_W-1:0]  divisor,
  output logic                        busy,
  output logic signed [SAMPLE_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic                  neg_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;

  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    diff;
  logic [SAMPLE_W-1:0]   mag;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= dividend[DIVIDEND_W-1];
      quo_r <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DIVIDEND_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      busy_r <= (step_r != STEP_W'(1));
    end
  end

  assign mag      = quo_r[SAMPLE_W-1:0];
  assign quotient = neg_r ? -mag : mag;
  assign busy     = busy_r;

endmodule

`default_nettype wire

// File: rtl/moving_mean_difference_filter.sv
// Each accepted input beat goes through ST_SUM (sum update, divider load),
// ST_DIV (bit-serial divide) and ST_FIN (result load, held while out is stalled).
// A new input beat is taken only in ST_IDLE, after the previous result is loaded.
// Reset clears sum, index, fill count and control; the window memory is not
// swept, since entries are only used once the window has been filled.
`default_nettype none

module moving_mean_difference_filter import mmdf_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  mmdf_in_if.sink    in_chan,
  mmdf_out_if.source out_chan
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  state_t state_r, state_nxt;
  win_ctrl_t win_ctrl;
  div_ctrl_t div_ctrl;

  logic signed [SUM_W-1:0]    sum_nxt;
  logic        [CNT_W-1:0]    count_nxt;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic signed [SAMPLE_W-1:0] quotient;
  logic                       div_busy;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic signed [SAMPLE_W-1:0] diff_r;
  logic                       out_load;

  mmdf_window #(.WINDOW(WINDOW)) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (win_ctrl),
    .sample_value (in_chan.sample_value),
    .starts_block (in_chan.starts_block),
    .sum_nxt      (sum_nxt),
    .count_nxt    (count_nxt),
    .cur_sample   (cur_sample)
  );

  mmdf_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_ctrl.load),
    .dividend (sum_nxt),
    .divisor  (count_nxt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    win_ctrl.accept = 1'b0;
    win_ctrl.update = 1'b0;
    div_ctrl.load   = 1'b0;
    div_ctrl.busy   = div_busy;
    out_load        = 1'b0;
    in_chan.ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready   = 1'b1;
        win_ctrl.accept = in_chan.valid;
        if (in_chan.valid) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        win_ctrl.update = 1'b1;
        div_ctrl.load   = 1'b1;
        state_nxt       = ST_DIV;
      end
      ST_DIV: begin
        if (!div_ctrl.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result register holds a finished beat while the next sample is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_r <= quotient;
      diff_r <= quotient - cur_sample;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.window_mean       = mean_r;
  assign out_chan.mean_minus_sample = diff_r;

  a_accept_to_sum : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == ST_SUM))
    else $error("accepted beat did not start a sum update");

  a_sum_starts_div : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |=> (div_busy && state_r == ST_DIV))
    else $error("divider not running after sum update");

  a_fin_div_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> !div_busy)
    else $error("result taken while divider still busy");

  a_load_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result beat not presented after load");

endmodule

`default_nettype wire

// File: verif/tb_moving_mean_difference_filter.sv
// Testbench for moving_mean_difference_filter: directed and random samples with
// random idling on both channels, checked beat by beat against a local window model.
// Depends on mmdf_pkg, mmdf_in_if, mmdf_out_if and the filter RTL.
`default_nettype none

module tb_moving_mean_difference_filter import mmdf_pkg::*; ();

  localparam int WIN         = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t mean_minus_sample;
    sample_t window_mean;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mmdf_in_if  in_chan ();
  mmdf_out_if out_chan ();

  moving_mean_difference_filter #(
    .WINDOW(WIN)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  sample_t      win_mem [WIN];
  int           win_sum;
  int           win_idx;
  int           win_fill;
  mean_result_t pending_means[$];

  bit idle_on;
  int stall_left;
  int quiet_cycles;
  int errors;
  int samples_sent;
  int blocks_started;
  int results_checked;

  function automatic void predict_mean_difference(sample_t value, logic first);
    mean_result_t r;
    int mean;
    if (first) begin
      foreach (win_mem[i]) win_mem[i] = '0;
      win_sum  = 0;
      win_idx  = 0;
      win_fill = 0;
    end
    win_sum = win_sum - int'(win_mem[win_idx]) + int'(value);
    win_mem[win_idx] = value;
    win_idx = (win_idx == WIN - 1) ? 0 : win_idx + 1;
    if (win_fill < WIN) win_fill++;
    mean = win_sum / win_fill;
    r.window_mean       = mean[SAMPLE_W-1:0];
    r.mean_minus_sample = SAMPLE_W'(mean - int'(value));
    pending_means.push_back(r);
  endfunction

  task automatic send_sample(input sample_t value, input logic first);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= value;
    in_chan.starts_block <= first;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_mean_difference(value, first);
    samples_sent++;
    if (first) blocks_started++;
  endtask

  function automatic sample_t pick_sample(int style);
    sample_t v;
    case (style)
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
      3: v = SAMPLE_W'($urandom_range(0, 15) - 8);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic test_first_after_reset();
    send_sample(16'sh7FFF, 1'b0);
  endtask

  task automatic test_full_scale_window();
    send_sample(16'sh8000, 1'b1);
    repeat (WIN - 1) send_sample(16'sh8000, 1'b0);
    repeat (3) send_sample(16'sh7FFF, 1'b0);
  endtask

  task automatic test_truncation_toward_zero();
    send_sample(16'sh0001, 1'b1);
    send_sample(-16'sd2, 1'b0);
    send_sample(-16'sd2, 1'b0);
  endtask

  task automatic test_random_blocks(input int budget);
    int sent;
    int len;
    int style;
    logic first;
    sent = 0;
    while (sent < budget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 7);
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(WIN + 1, 80)
                                            : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        send_sample(pick_sample(style), first);
      end
      sent += len;
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_sample(pick_sample($urandom_range(0, 7)), $urandom_range(0, 19) == 0);
    end
  endtask

  always @(posedge clk) begin
    mean_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left   = 0;
      quiet_cycles = 0;
    end else begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_means.size() == 0) begin
          errors++;
          $error("result beat with no expectation: mean_minus_sample %0d window_mean %0d",
                 out_chan.mean_minus_sample, out_chan.window_mean);
        end else begin
          want = pending_means.pop_front();
          results_checked++;
          if (out_chan.mean_minus_sample !== want.mean_minus_sample) begin
            errors++;
            $error("mean_minus_sample: expected %0d, actual %0d",
                   want.mean_minus_sample, out_chan.mean_minus_sample);
          end
          if (out_chan.window_mean !== want.window_mean) begin
            errors++;
            $error("window_mean: expected %0d, actual %0d",
                   want.window_mean, out_chan.window_mean);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** moving_mean_difference_filter: FAILED **");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.sample_value <= '0;
    in_chan.starts_block <= 1'b0;
    foreach (win_mem[i]) win_mem[i] = '0;
    win_sum  = 0;
    win_idx  = 0;
    win_fill = 0;
    idle_on  = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_after_reset();
    test_full_scale_window();
    test_truncation_toward_zero();
    test_random_blocks(1230);
    test_back_to_back(300);

    in_chan.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d samples in %0d blocks with random idling and full-scale windows.",
             samples_sent, blocks_started);
    $display("Checked %0d result beats, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("** moving_mean_difference_filter: PASSED **");
    end else begin
      $display("** moving_mean_difference_filter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: moving_mean_difference_filter.f
rtl/mmdf_pkg.sv
rtl/mmdf_in_if.sv
rtl/mmdf_out_if.sv
rtl/mmdf_window.sv
rtl/mmdf_divider.sv
rtl/moving_mean_difference_filter.sv
verif/tb_moving_mean_difference_filter.sv
